>>> src/tlbfl_pkg.sv
// Package: shared types, constants and codes for the TLB cell row.
`default_nettype none
package tlbfl_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CFG_CNT_W = 5;
    localparam int CMP_W     = (IDX_W + 1 > CFG_CNT_W) ? IDX_W + 1 : CFG_CNT_W;
    localparam int CFG_W     = 5;
    localparam int STAMP_W   = 32;

    // operation codes
    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    // register indexes
    localparam logic CFG_USE_LRU = 1'b0;
    localparam logic CFG_ENTRIES = 1'b1;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] proc_id;
        logic [11:0] segment_num;
        logic [15:0] page_num;
        logic [15:0] new_frame;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] found_frame;
    } rsp_t;

    // token handed from cell to cell during a search pass
    typedef struct packed {
        logic               active;
        logic               sel_found;  // lookup: first hit; insert: first empty
        logic [IDX_W-1:0]   sel_idx;
        logic [15:0]        frame;
        logic               best_ok;
        logic [STAMP_W-1:0] best_stamp;
        logic [IDX_W-1:0]   best_idx;
    } carry_t;

    // entry update broadcast at the end of a pass
    typedef struct packed {
        logic               en;
        logic               fill;       // write tag and frame too
        logic [IDX_W-1:0]   idx;
        logic [15:0]        proc_id;
        logic [11:0]        segment_num;
        logic [15:0]        page_num;
        logic [15:0]        frame;
        logic [STAMP_W-1:0] stamp;
    } wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_COMMIT
    } state_t;

endpackage
`default_nettype wire

>>> src/tlbfl_cell.sv
// One TLB entry plus its stage of the search token.
`default_nettype none
module tlbfl_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [tlbfl_pkg::IDX_W-1:0] cell_idx,
    input  wire logic                  cell_en,
    input  wire tlbfl_pkg::req_t       req,
    input  wire tlbfl_pkg::carry_t     carry_in,
    input  wire tlbfl_pkg::wr_t        wr,
    output tlbfl_pkg::carry_t          carry_out
);
    import tlbfl_pkg::*;

    logic               valid_reg, valid_next;
    logic [15:0]        proc_reg;
    logic [11:0]        seg_reg;
    logic [15:0]        page_reg;
    logic [15:0]        frame_reg;
    logic [STAMP_W-1:0] stamp_reg;
    carry_t             carry_reg, carry_next;
    logic               proc_eq;
    logic               tag_hit;
    logic               wr_here;

    assign proc_eq = cell_en && valid_reg && (proc_reg == req.proc_id);
    assign tag_hit = proc_eq && (seg_reg == req.segment_num) && (page_reg == req.page_num);
    assign wr_here = wr.en && (wr.idx == cell_idx);

    always_comb
    begin
        carry_next = carry_in;
        valid_next = valid_reg;
        if (carry_in.active)
        begin
            unique case (req.func)
                FUNC_LOOKUP:
                begin
                    if (!carry_in.sel_found && tag_hit)
                    begin
                        carry_next.sel_found = 1'b1;
                        carry_next.sel_idx   = cell_idx;
                        carry_next.frame     = frame_reg;
                    end
                end
                FUNC_INSERT:
                begin
                    if (cell_en && !valid_reg && !carry_in.sel_found)
                    begin
                        carry_next.sel_found = 1'b1;
                        carry_next.sel_idx   = cell_idx;
                    end
                    // oldest stamp, strict compare keeps the lowest index on ties
                    if (cell_en && valid_reg &&
                        (!carry_in.best_ok || (stamp_reg < carry_in.best_stamp)))
                    begin
                        carry_next.best_ok    = 1'b1;
                        carry_next.best_stamp = stamp_reg;
                        carry_next.best_idx   = cell_idx;
                    end
                end
                FUNC_FLUSH:
                begin
                    if (proc_eq)
                    begin
                        valid_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (wr_here && wr.fill)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_here)
        begin
            stamp_reg <= wr.stamp;
            if (wr.fill)
            begin
                proc_reg  <= wr.proc_id;
                seg_reg   <= wr.segment_num;
                page_reg  <= wr.page_num;
                frame_reg <= wr.frame;
            end
        end
    end

    assign carry_out = carry_reg;

endmodule
`default_nettype wire

>>> src/tlb_fifo_lru_lookup_replace.sv
// Top level: fully associative TLB with LRU/FIFO replacement on a row of entry cells.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  cfg      | in        | cfg_we                 | cfg_index, cfg_data
//  in       | in        | in_valid / in_ready    | in_data  (func, tags, frame)
//  out      | out       | out_valid / out_ready  | out_data (hit, found_frame)
//
// Each request is carried as a token down the row of ENTRIES cells, one cell
// per cycle; every cell checks its own entry against the request and hands the
// running search result (first hit, first empty entry, oldest stamp) onward.
// The commit state then restamps or fills the chosen entry and loads the result.
// Flush clears matching entries as the token passes each cell.
// in_ready is high only between requests; a result waiting on out_ready does
// not block the next accept, only the next commit.
// Reset clears valid bits, the stamp counter and the tokens and resets the control
// registers; entry tags, frames and stamps stay unreset, only read behind a valid bit.
`default_nettype none
module tlb_fifo_lru_lookup_replace (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [tlbfl_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire tlbfl_pkg::req_t             in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output tlbfl_pkg::rsp_t                  out_data
);
    import tlbfl_pkg::*;

    state_t                 state_reg, state_next;
    logic                   use_lru_reg;
    logic [CFG_CNT_W-1:0]   eiu_reg;
    logic [STAMP_W-1:0]     next_stamp_reg, next_stamp_next;
    logic                   start_reg;
    req_t                   req_reg;
    carry_t                 fin_reg;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_data_reg;

    carry_t                 chain [ENTRIES+1];
    logic [ENTRIES-1:0]     cell_en;
    wr_t                    wr;
    logic                   in_fire;
    logic                   commit_go;
    logic                   is_lookup;
    logic                   is_insert;
    rsp_t                   rsp;

    assign in_fire   = in_valid && in_ready;
    assign is_lookup = (req_reg.func == FUNC_LOOKUP);
    assign is_insert = (req_reg.func == FUNC_INSERT);

    // entry i takes part when i < max(1, entries_in_use); above ENTRIES clips itself
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_en
        assign cell_en[i] = (i == 0) || (CMP_W'(i) < CMP_W'(eiu_reg));
    end

    // token injected at the head of the row; active is the leading field
    assign chain[0] = {start_reg, {($bits(carry_t)-1){1'b0}}};

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        tlbfl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_W'(i)),
            .cell_en   (cell_en[i]),
            .req       (req_reg),
            .carry_in  (chain[i]),
            .wr        (wr),
            .carry_out (chain[i+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (chain[ENTRIES].active)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        commit_go = (state_reg == ST_COMMIT) && (!out_valid_reg || out_ready);

        rsp.hit         = is_lookup && fin_reg.sel_found;
        rsp.found_frame = rsp.hit ? fin_reg.frame : 16'd0;

        wr.en          = commit_go &&
                         (is_insert || (is_lookup && fin_reg.sel_found && use_lru_reg));
        wr.fill        = is_insert;
        wr.idx         = (is_insert && !fin_reg.sel_found) ? fin_reg.best_idx
                                                           : fin_reg.sel_idx;
        wr.proc_id     = req_reg.proc_id;
        wr.segment_num = req_reg.segment_num;
        wr.page_num    = req_reg.page_num;
        wr.frame       = req_reg.new_frame;
        wr.stamp       = next_stamp_reg;

        // saturating stamp counter
        next_stamp_next = next_stamp_reg;
        if (wr.en && (next_stamp_reg != STAMP_MAX))
        begin
            next_stamp_next = next_stamp_reg + STAMP_W'(1);
        end

        out_valid_next = out_valid_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            use_lru_reg    <= 1'b0;
            eiu_reg        <= CFG_CNT_W'(16);
            next_stamp_reg <= '0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_stamp_reg <= next_stamp_next;
            start_reg      <= in_fire;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_USE_LRU: use_lru_reg <= cfg_data[0];
                    CFG_ENTRIES: eiu_reg     <= cfg_data[CFG_CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_data;
        end
        if ((state_reg == ST_WALK) && chain[ENTRIES].active)
        begin
            fin_reg <= chain[ENTRIES];
        end
        if (commit_go)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
